// ===== rtl/traffic_light_pedestrian_sequencer_assert.svh =====
// ---------------------------------------------------------------------------
// Traffic light sequencer assertion macros
// Clocked assertion wrappers; compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_PEDESTRIAN_SEQUENCER_ASSERT_SVH
`define TRAFFIC_LIGHT_PEDESTRIAN_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF
// check outside reset
`define TLPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every edge, reset included
`define TLPS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLPS_ASSERT(label, clk, rst_n, prop, msg)
`define TLPS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/tlps_pkg.sv =====
// ---------------------------------------------------------------------------
// Traffic light sequencer package
// Item types, phase codes, register map and the lamp decode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlps_pkg;

    localparam int TIMER_BITS_DEF = 24;
    localparam int CFG_W          = 24;
    localparam int PH_W           = 3;
    localparam int ADDR_W         = 4;

    localparam logic [PH_W-1:0] PH_NS_GREEN  = 3'd0;
    localparam logic [PH_W-1:0] PH_NS_YELLOW = 3'd1;
    localparam logic [PH_W-1:0] PH_EW_GREEN  = 3'd2;
    localparam logic [PH_W-1:0] PH_EW_YELLOW = 3'd3;
    localparam logic [PH_W-1:0] PH_NS_WALK   = 3'd4;
    localparam logic [PH_W-1:0] PH_EW_WALK   = 3'd5;

    localparam logic [1:0] REG_GREEN  = 2'd0;
    localparam logic [1:0] REG_YELLOW = 2'd1;
    localparam logic [1:0] REG_WALK   = 2'd2;

    localparam logic [CFG_W-1:0] GREEN_RST  = 24'd5000;
    localparam logic [CFG_W-1:0] YELLOW_RST = 24'd2000;
    localparam logic [CFG_W-1:0] WALK_RST   = 24'd4000;

    typedef struct packed {
        logic tick;
        logic ns_request;
        logic ew_request;
    } t_in_item;

    typedef struct packed {
        logic [PH_W-1:0] phase;
        logic            ns_green;
        logic            ns_yellow;
        logic            ns_red;
        logic            ew_green;
        logic            ew_yellow;
        logic            ew_red;
        logic            ns_walk;
        logic            ns_dont_walk;
        logic            ew_walk;
        logic            ew_dont_walk;
    } t_out_item;

    // sequencer control state other than the timer
    typedef struct packed {
        logic [PH_W-1:0] phase;
        logic            ns_pending;
        logic            ew_pending;
    } t_seq_ctrl;

    function automatic t_out_item lamps(input logic [PH_W-1:0] ph);
        t_out_item o;
        o = '0;
        o.phase        = ph;
        o.ns_red       = 1'b1;
        o.ew_red       = 1'b1;
        o.ns_dont_walk = 1'b1;
        o.ew_dont_walk = 1'b1;
        case (ph)
            PH_NS_YELLOW: begin
                o.ns_red    = 1'b0;
                o.ns_yellow = 1'b1;
            end
            PH_EW_GREEN: begin
                o.ew_red   = 1'b0;
                o.ew_green = 1'b1;
            end
            PH_EW_YELLOW: begin
                o.ew_red    = 1'b0;
                o.ew_yellow = 1'b1;
            end
            PH_NS_WALK: begin
                o.ns_walk      = 1'b1;
                o.ns_dont_walk = 1'b0;
            end
            PH_EW_WALK: begin
                o.ew_walk      = 1'b1;
                o.ew_dont_walk = 1'b0;
            end
            default: begin
                o.ns_red   = 1'b0;
                o.ns_green = 1'b1;
            end
        endcase
        return o;
    endfunction

endpackage

// ===== rtl/tlps_step.sv =====
// ---------------------------------------------------------------------------
// Traffic light sequencer step
// Next phase, timer and pending flags for one request, plus lamp decode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlps_step #(
    parameter int TIMER_BITS = tlps_pkg::TIMER_BITS_DEF
) (
    input  tlps_pkg::t_seq_ctrl               i_ctrl,
    input  logic [TIMER_BITS-1:0]             i_elapsed,
    input  tlps_pkg::t_in_item                i_item,
    input  logic [tlps_pkg::CFG_W-1:0]        i_green_time,
    input  logic [tlps_pkg::CFG_W-1:0]        i_yellow_time,
    input  logic [tlps_pkg::CFG_W-1:0]        i_walk_time,
    output tlps_pkg::t_seq_ctrl               o_ctrl,
    output logic [TIMER_BITS-1:0]             o_elapsed,
    output tlps_pkg::t_out_item               o_item
);
    import tlps_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    logic            ns_p;
    logic            ew_p;
    logic [PH_W-1:0] ph;
    logic [PH_W-1:0] nxt;
    logic [TIMER_BITS-1:0] inc;
    logic [CFG_W-1:0]      dur;
    logic                  done;

    always_comb begin
        ns_p = i_ctrl.ns_pending | i_item.ns_request;
        ew_p = i_ctrl.ew_pending | i_item.ew_request;
        ph   = (i_ctrl.phase > PH_EW_WALK) ? PH_NS_GREEN : i_ctrl.phase;

        // saturate at all ones
        inc = (&i_elapsed) ? i_elapsed : i_elapsed + 1'b1;

        case (ph)
            PH_NS_YELLOW, PH_EW_YELLOW: dur = i_yellow_time;
            PH_NS_WALK, PH_EW_WALK:     dur = i_walk_time;
            default:                    dur = i_green_time;
        endcase

        done = (CMP_W'(inc) >= CMP_W'(dur));

        case (ph)
            PH_NS_GREEN:  nxt = PH_NS_YELLOW;
            PH_EW_GREEN:  nxt = PH_EW_YELLOW;
            PH_NS_YELLOW: nxt = ns_p ? PH_NS_WALK : (ew_p ? PH_EW_WALK : PH_EW_GREEN);
            PH_EW_YELLOW: nxt = ns_p ? PH_NS_WALK : (ew_p ? PH_EW_WALK : PH_NS_GREEN);
            PH_NS_WALK:   nxt = PH_EW_GREEN;
            default:      nxt = PH_NS_GREEN;
        endcase

        o_ctrl.phase      = ph;
        o_ctrl.ns_pending = ns_p;
        o_ctrl.ew_pending = ew_p;
        o_elapsed         = i_elapsed;

        if (i_item.tick) begin
            o_elapsed = inc;
            if (done) begin
                o_elapsed    = '0;
                o_ctrl.phase = nxt;
                // a yellow end consumes the request it serves
                if (ph == PH_NS_YELLOW || ph == PH_EW_YELLOW) begin
                    if (ns_p) begin
                        o_ctrl.ns_pending = 1'b0;
                    end else begin
                        o_ctrl.ew_pending = 1'b0;
                    end
                end
            end
        end

        o_item = lamps(o_ctrl.phase);
    end

endmodule

// ===== rtl/traffic_light_pedestrian_sequencer.sv =====
// ---------------------------------------------------------------------------
// Traffic light pedestrian sequencer
// Two-road phase sequencer with latched pedestrian requests, walk phases
// and an APB register file for the phase durations.
// ---------------------------------------------------------------------------
//  channel   handshake                    payload
//  input     i_in_valid / o_in_ready      i_in_item  (tick, ns/ew request)
//  result    o_out_valid / i_out_ready    o_out_item (phase, ten lamps)
//  config    psel/penable/pwrite/pready   paddr, pwdata, prdata
//
//  One request per cycle while results are taken: each accepted request goes
//  through the step logic and lands in the result register on the edge that
//  accepts it. tlps_step sets the rate: a single compare and phase update.
//  Synchronous active-low reset returns phase to NS green, clears the timer,
//  the pending flags and the result valid, and reloads default durations.
//  A stalled result holds the input off only when the result register is
//  full and not being taken in the same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "traffic_light_pedestrian_sequencer_assert.svh"

module traffic_light_pedestrian_sequencer #(
    parameter int TIMER_BITS = tlps_pkg::TIMER_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tlps_pkg::t_in_item            i_in_item,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tlps_pkg::t_out_item           o_out_item,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlps_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tlps_pkg::*;

    // duration registers
    logic [CFG_W-1:0] r_green_time;
    logic [CFG_W-1:0] r_yellow_time;
    logic [CFG_W-1:0] r_walk_time;

    // sequencer state
    t_seq_ctrl             r_ctrl;
    t_seq_ctrl             n_ctrl;
    logic [TIMER_BITS-1:0] r_elapsed;
    logic [TIMER_BITS-1:0] n_elapsed;

    // result register
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    logic       in_accept;
    logic       cfg_write;
    logic [1:0] reg_idx;

    assign reg_idx   = paddr[ADDR_W-1:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // take a new request whenever the result slot frees up this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // register read-back, unused addresses read zero
    always_comb begin
        case (reg_idx)
            REG_GREEN:  prdata = 32'(r_green_time);
            REG_YELLOW: prdata = 32'(r_yellow_time);
            REG_WALK:   prdata = 32'(r_walk_time);
            default:    prdata = '0;
        endcase
    end

    // write durations; drop writes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green_time  <= GREEN_RST;
            r_yellow_time <= YELLOW_RST;
            r_walk_time   <= WALK_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_GREEN:  r_green_time  <= pwdata[CFG_W-1:0];
                REG_YELLOW: r_yellow_time <= pwdata[CFG_W-1:0];
                REG_WALK:   r_walk_time   <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tlps_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_ctrl        (r_ctrl),
        .i_elapsed     (r_elapsed),
        .i_item        (i_in_item),
        .i_green_time  (r_green_time),
        .i_yellow_time (r_yellow_time),
        .i_walk_time   (r_walk_time),
        .o_ctrl        (n_ctrl),
        .o_elapsed     (n_elapsed),
        .o_item        (n_out_item)
    );

    // advance state only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.phase      <= PH_NS_GREEN;
            r_ctrl.ns_pending <= 1'b0;
            r_ctrl.ew_pending <= 1'b0;
            r_elapsed         <= '0;
        end else if (in_accept) begin
            r_ctrl    <= n_ctrl;
            r_elapsed <= n_elapsed;
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_item <= n_out_item;
        end
    end

    `TLPS_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |-> !o_in_ready, "result overwritten while stalled")
    `TLPS_ASSERT(a_hold_no_tick, i_clk, i_rst_n, (in_accept && !i_in_item.tick) |=> (r_ctrl.phase == $past(r_ctrl.phase)), "phase moved without a tick")
    `TLPS_ASSERT(a_walk_from_yellow, i_clk, i_rst_n, ((r_ctrl.phase == PH_NS_WALK || r_ctrl.phase == PH_EW_WALK) && $past(r_ctrl.phase) != r_ctrl.phase) |-> ($past(r_ctrl.phase) == PH_NS_YELLOW || $past(r_ctrl.phase) == PH_EW_YELLOW), "walk entered from a non-yellow phase")
    `TLPS_ASSERT(a_result_phase, i_clk, i_rst_n, in_accept |=> (r_out_valid && r_out_item.phase == r_ctrl.phase), "result phase differs from state")
    `TLPS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !r_out_valid, "result valid after reset")

endmodule

// ===== dv/tb_traffic_light_pedestrian_sequencer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Traffic light pedestrian sequencer testbench
// Drives tick and crossing requests through the valid/ready input channel,
// programs the phase durations over the register port while the block is
// idle, and checks every phase/lamp result against a cycle-free predictor
// of the sequencer kept inside the bench.
// ---------------------------------------------------------------------------

module tb_traffic_light_pedestrian_sequencer;

    import tlps_pkg::*;

    localparam int TIMER_BITS      = TIMER_BITS_DEF;
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 163;
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES    = 4;     // settle time after the last result
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int REQ_PCT         = 10;    // chance of each crossing request

    // index past the register map; writes there must be ignored
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam logic [CFG_W-1:0] FULL_SCALE = '1;

    // -----------------------------------------------------------------------
    // Clock, reset and DUT ports
    // -----------------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_W-1:0]     paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    traffic_light_pedestrian_sequencer #(
        .TIMER_BITS (TIMER_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // -----------------------------------------------------------------------
    // Bench state
    // -----------------------------------------------------------------------
    t_in_item  request_q[$];       // requests waiting for the driver
    t_out_item expected_lamps[$];  // predicted results, oldest first

    // predictor copy of the sequencer and its durations
    logic [PH_W-1:0]       seq_phase   = PH_NS_GREEN;
    logic [TIMER_BITS-1:0] seq_elapsed = '0;
    logic                  ns_pend     = 1'b0;
    logic                  ew_pend     = 1'b0;
    logic [CFG_W-1:0]      green_ms    = GREEN_RST;
    logic [CFG_W-1:0]      yellow_ms   = YELLOW_RST;
    logic [CFG_W-1:0]      walk_ms     = WALK_RST;

    // handshake flags, sampled at the rising edge, read by the drivers
    bit in_fire  = 1'b0;
    bit out_fire = 1'b0;

    // idle shaping, set per phase by the stimulus
    bit idle_send = 1'b1;
    bit idle_recv = 1'b1;
    int send_gap  = 0;
    int recv_gap  = 0;

    // receiver hold-off requests and the receiver's own count
    int press_asks   = 0;
    int press_served = 0;
    int hold_left    = 0;

    int quiet_cycles   = 0;
    int mismatches     = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int settings_used  = 0;
    int ns_walks       = 0;
    int ew_walks       = 0;

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // Lamp pattern for a phase: both reds and both don't-walks lit unless
    // the phase turns one of them off.
    function automatic t_out_item lamp_pattern(input logic [PH_W-1:0] ph);
        t_out_item lit;
        lit              = '0;
        lit.phase        = ph;
        lit.ns_red       = 1'b1;
        lit.ew_red       = 1'b1;
        lit.ns_dont_walk = 1'b1;
        lit.ew_dont_walk = 1'b1;
        case (ph)
            PH_NS_GREEN: begin
                lit.ns_red   = 1'b0;
                lit.ns_green = 1'b1;
            end
            PH_NS_YELLOW: begin
                lit.ns_red    = 1'b0;
                lit.ns_yellow = 1'b1;
            end
            PH_EW_GREEN: begin
                lit.ew_red   = 1'b0;
                lit.ew_green = 1'b1;
            end
            PH_EW_YELLOW: begin
                lit.ew_red    = 1'b0;
                lit.ew_yellow = 1'b1;
            end
            PH_NS_WALK: begin
                lit.ns_walk      = 1'b1;
                lit.ns_dont_walk = 1'b0;
            end
            PH_EW_WALK: begin
                lit.ew_walk      = 1'b1;
                lit.ew_dont_walk = 1'b0;
            end
            default: begin
                lit.ns_red   = 1'b0;
                lit.ns_green = 1'b1;
            end
        endcase
        return lit;
    endfunction

    // Advance the sequencer by one request and return the lamps after it.
    function automatic t_out_item advance_sequencer(input t_in_item req);
        logic [31:0]     limit_ms;
        logic [31:0]     elapsed_wide;
        logic [PH_W-1:0] nxt;
        // latch crossing requests before the timer is looked at
        if (req.ns_request) ns_pend = 1'b1;
        if (req.ew_request) ew_pend = 1'b1;
        if (seq_phase > PH_EW_WALK) seq_phase = PH_NS_GREEN;
        if (req.tick) begin
            // saturate rather than wrap
            if (seq_elapsed != '1) seq_elapsed = seq_elapsed + 1'b1;
            case (seq_phase)
                PH_NS_YELLOW, PH_EW_YELLOW: limit_ms = 32'(yellow_ms);
                PH_NS_WALK, PH_EW_WALK:     limit_ms = 32'(walk_ms);
                default:                    limit_ms = 32'(green_ms);
            endcase
            elapsed_wide = 32'(seq_elapsed);
            if (elapsed_wide >= limit_ms) begin
                seq_elapsed = '0;
                case (seq_phase)
                    PH_NS_GREEN: nxt = PH_NS_YELLOW;
                    PH_EW_GREEN: nxt = PH_EW_YELLOW;
                    PH_NS_YELLOW, PH_EW_YELLOW: begin
                        // north-south crossing wins over east-west
                        if (ns_pend) begin
                            ns_pend = 1'b0;
                            nxt     = PH_NS_WALK;
                            ns_walks++;
                        end else if (ew_pend) begin
                            ew_pend = 1'b0;
                            nxt     = PH_EW_WALK;
                            ew_walks++;
                        end else if (seq_phase == PH_NS_YELLOW) begin
                            nxt = PH_EW_GREEN;
                        end else begin
                            nxt = PH_NS_GREEN;
                        end
                    end
                    PH_NS_WALK: nxt = PH_EW_GREEN;
                    default:    nxt = PH_NS_GREEN;
                endcase
                seq_phase = nxt;
            end
        end
        return lamp_pattern(seq_phase);
    endfunction

    function automatic void check_field(input string name, input logic [PH_W-1:0] want,
                                        input logic [PH_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_bit(input string name, input logic want,
                                      input logic got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // -----------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge, predict on every
    // accepted request and compare every accepted result
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        in_fire  = i_rst_n && i_in_valid && o_in_ready;
        out_fire = i_rst_n && o_out_valid && i_out_ready;
        if (in_fire) begin
            expected_lamps.push_back(advance_sequencer(i_in_item));
            requests_sent++;
        end
        if (out_fire) begin
            results_seen++;
            if (expected_lamps.size() == 0) begin
                $error("result with nothing expected: phase %0d", o_out_item.phase);
                mismatches++;
            end else begin
                want = expected_lamps.pop_front();
                check_field("phase",      want.phase,        o_out_item.phase);
                check_bit("ns_green",     want.ns_green,     o_out_item.ns_green);
                check_bit("ns_yellow",    want.ns_yellow,    o_out_item.ns_yellow);
                check_bit("ns_red",       want.ns_red,       o_out_item.ns_red);
                check_bit("ew_green",     want.ew_green,     o_out_item.ew_green);
                check_bit("ew_yellow",    want.ew_yellow,    o_out_item.ew_yellow);
                check_bit("ew_red",       want.ew_red,       o_out_item.ew_red);
                check_bit("ns_walk",      want.ns_walk,      o_out_item.ns_walk);
                check_bit("ns_dont_walk", want.ns_dont_walk, o_out_item.ns_dont_walk);
                check_bit("ew_walk",      want.ew_walk,      o_out_item.ew_walk);
                check_bit("ew_dont_walk", want.ew_dont_walk, o_out_item.ew_dont_walk);
            end
        end
        // any handshake, register write included, counts as progress
        if (!i_rst_n || in_fire || out_fire || (psel && penable && pwrite && pready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
    end

    // -----------------------------------------------------------------------
    // Driver: present the next request at the falling edge once the last
    // one was taken and its drawn gap has run out
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (send_gap != 0) begin
                send_gap = send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (request_q.size() != 0) begin
                i_in_item  <= request_q.pop_front();
                i_in_valid <= 1'b1;
                send_gap = idle_send ? $urandom_range(0, 11) : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: drop ready for a drawn number of cycles after each result,
    // or for a long stretch when a hold-off is asked for
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (press_served != press_asks) begin
            press_served = press_asks;
            hold_left    = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!i_out_ready || out_fire) begin
            if (recv_gap != 0) begin
                recv_gap = recv_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                recv_gap = idle_recv ? $urandom_range(0, 11) : 0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    task automatic push_req(input logic tick, input logic ns_req, input logic ew_req);
        t_in_item req;
        req.tick       = tick;
        req.ns_request = ns_req;
        req.ew_request = ew_req;
        request_q.push_back(req);
    endtask

    // Write one duration register; the top byte carries junk that the
    // block has to drop.
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        logic [31:0] word;
        word          = '0;
        word[CFG_W-1:0] = val;
        word[31:24]   = 8'($urandom_range(0, 255));
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_GREEN:  green_ms  = val;
            REG_YELLOW: yellow_ms = val;
            REG_WALK:   walk_ms   = val;
            default:    ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_durations(input logic [CFG_W-1:0] green,
                                     input logic [CFG_W-1:0] yellow,
                                     input logic [CFG_W-1:0] walk);
        write_reg(REG_GREEN, green);
        write_reg(REG_YELLOW, yellow);
        write_reg(REG_WALK, walk);
        settings_used++;
    endtask

    // Hold until every queued request went in and every result came out,
    // then let the pipeline settle.
    task automatic wait_idle();
        while (request_q.size() != 0 || i_in_valid || expected_lamps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // -----------------------------------------------------------------------
    // Watchdog: end the run if no handshake happens for too long
    // -----------------------------------------------------------------------
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        logic [CFG_W-1:0] green_set;
        logic [CFG_W-1:0] yellow_set;
        logic [CFG_W-1:0] walk_set;
        int               tick_pct;
        t_in_item         req;

        // hold reset low first, release it at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset durations: the timer must count and hold, nothing ends.
        push_req(1'b0, 1'b0, 1'b0);
        push_req(1'b1, 1'b0, 1'b0);
        push_req(1'b1, 1'b0, 1'b0);
        wait_idle();

        // Zero durations: every tick ends the phase. Walk the full cycle,
        // serve a request arriving on a yellow end, and both requests at
        // once with north-south taking priority.
        program_durations('0, '0, '0);
        settings_used--;
        settings_used++;
        @(posedge i_clk);
        push_req(1'b1, 1'b0, 1'b0);  // NS green -> NS yellow
        push_req(1'b1, 1'b1, 1'b0);  // request on yellow end -> NS walk
        push_req(1'b1, 1'b0, 1'b0);  // NS walk -> EW green
        push_req(1'b1, 1'b0, 1'b0);  // -> EW yellow
        push_req(1'b1, 1'b0, 1'b1);  // request on yellow end -> EW walk
        push_req(1'b1, 1'b0, 1'b0);  // EW walk -> NS green
        push_req(1'b0, 1'b1, 1'b1);  // latch both without a tick
        push_req(1'b1, 1'b0, 1'b0);  // -> NS yellow
        push_req(1'b1, 1'b0, 1'b0);  // north-south served first
        push_req(1'b1, 1'b0, 1'b0);  // -> EW green
        push_req(1'b1, 1'b0, 1'b0);  // -> EW yellow
        push_req(1'b1, 1'b0, 1'b0);  // east-west still pending
        push_req(1'b1, 1'b0, 1'b0);  // -> NS green
        push_req(1'b0, 1'b0, 1'b0);  // no tick, hold
        wait_idle();

        // Full-scale durations hold the phase; the spare index is ignored.
        program_durations(FULL_SCALE, FULL_SCALE, FULL_SCALE);
        write_reg(REG_SPARE, 24'h000001);
        @(posedge i_clk);
        push_req(1'b1, 1'b1, 1'b0);
        push_req(1'b1, 1'b0, 1'b1);
        push_req(1'b1, 1'b1, 1'b1);
        push_req(1'b0, 1'b0, 1'b0);
        wait_idle();

        // Random phases: mostly ticking traffic with short durations so the
        // sequence keeps cycling, a few full-scale settings that park it,
        // and both sides idling in different combinations.
        for (int p = 0; p < RAND_PHASES; p++) begin
            green_set  = CFG_W'($urandom_range(0, 8));
            yellow_set = CFG_W'($urandom_range(0, 4));
            walk_set   = CFG_W'($urandom_range(0, 6));
            if (p == 2) green_set = CFG_W'($urandom_range(20, 40));
            if (p == 4) green_set = FULL_SCALE;
            if (p == 7) walk_set = FULL_SCALE;
            if (p == 9) begin
                green_set  = '0;
                yellow_set = '0;
                walk_set   = '0;
            end
            program_durations(green_set, yellow_set, walk_set);

            idle_send = (p % 4 == 0) || (p % 4 == 2);
            idle_recv = (p % 4 == 0) || (p % 4 == 3);
            tick_pct  = (p % 3 == 0) ? 100 : $urandom_range(50, 90);

            @(posedge i_clk);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                req.tick       = ($urandom_range(0, 99) < tick_pct);
                req.ns_request = ($urandom_range(0, 99) < REQ_PCT);
                req.ew_request = ($urandom_range(0, 99) < REQ_PCT);
                request_q.push_back(req);
            end
            // stall the result side for a long stretch so the input backs up
            if (p == 1 || p == 6) press_asks++;
            wait_idle();
        end

        if (expected_lamps.size() != 0) begin
            $error("%0d expected results never arrived", expected_lamps.size());
            mismatches++;
        end

        $display("Run covered %0d requests and %0d results over %0d duration settings,",
                 requests_sent, results_seen, settings_used);
        $display("zero and full-scale timers included; walks entered: %0d NS, %0d EW.",
                 ns_walks, ew_walks);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tlps_pkg.sv
rtl/tlps_step.sv
rtl/traffic_light_pedestrian_sequencer.sv
dv/tb_traffic_light_pedestrian_sequencer.sv
